/* sv/firmware_bundle_text_parser_core_defines.svh */
// Assertion macros used by the checker file of the bundle text parser.
// No dependencies; expects clk and arst_n in the scope of use.
`ifndef FIRMWARE_BUNDLE_TEXT_PARSER_CORE_DEFINES_SVH
`define FIRMWARE_BUNDLE_TEXT_PARSER_CORE_DEFINES_SVH

// same-cycle implication
`define FBTP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fbtp check failed");

// next-cycle implication
`define FBTP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fbtp check failed");

`endif

/* sv/fbtp_pkg.sv */
// Package of the bundle text parser: types, codes, name and limit tables.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fbtp_pkg;

	localparam int LINE_LIMIT  = 32;
	localparam int IMAGE_KINDS = 11;
	localparam int LEN_W       = $clog2(LINE_LIMIT);
	localparam int MAX_RES     = 3;

	typedef enum logic [1:0] {PH_NAME, PH_COUNT, PH_DATA, PH_FAIL} phase_t;
	typedef enum logic [2:0] {F_START, F_PLUS, F_ZERO, F_PREFIX, F_DIGITS, F_BAD} form_t;

	typedef logic [1:0] kind_t;
	localparam kind_t KIND_WORD   = 2'd0;
	localparam kind_t KIND_IMAGE  = 2'd1;
	localparam kind_t KIND_ACCEPT = 2'd2;
	localparam kind_t KIND_ERROR  = 2'd3;

	typedef logic [3:0] err_t;
	localparam err_t ERR_TOO_LONG   = 4'd0;
	localparam err_t ERR_UNKNOWN    = 4'd1;
	localparam err_t ERR_NO_SIZE    = 4'd2;
	localparam err_t ERR_BAD_SIZE   = 4'd3;
	localparam err_t ERR_TOO_BIG    = 4'd4;
	localparam err_t ERR_NO_DATA    = 4'd5;
	localparam err_t ERR_BAD_DATA   = 4'd6;
	localparam err_t ERR_DUPLICATE  = 4'd7;
	localparam err_t ERR_NO_UTILITY = 4'd8;

	typedef struct packed {
		phase_t                 phase;
		logic [LEN_W-1:0]       line_length;
		logic [IMAGE_KINDS-1:0] name_candidates;
		logic [31:0]            acc;
		logic                   ovf;
		form_t                  form;
		logic [3:0]             cur_image;
		logic [15:0]            words_expected;
		logic [15:0]            words_done;
		logic [IMAGE_KINDS-1:0] images_seen;
		logic                   line_stopped;
	} parse_state_t;

	localparam parse_state_t STATE_RESET = '{
		phase: PH_NAME, line_length: '0, name_candidates: '1, acc: '0, ovf: 1'b0,
		form: F_START, cur_image: '0, words_expected: '0, words_done: '0,
		images_seen: '0, line_stopped: 1'b0};

	typedef struct packed {
		kind_t       kind;
		logic [3:0]  image_id;
		logic [15:0] word_index;
		logic [31:0] word_value;
		err_t        error_code;
		logic        final_res;
	} result_t;

	typedef struct packed {
		logic       load;
		logic [1:0] count;
	} q_load_t;

	localparam logic [8*7-1:0] UTIL_TXT = "utility";
	localparam logic [8*8-1:0] FW_TXT   = "firmware";
	localparam logic [8*6-1:0] CFG_TXT  = "config";

	function automatic logic [3:0] name_len(input logic [3:0] id);
		logic [3:0] n;
		n = 4'd0;
		case (id) inside
			4'd0:          n = 4'd7;
			[4'd1:4'd3]:   n = 4'd9;
			[4'd4:4'd10]:  n = 4'd7;
			default:       n = 4'd0;
		endcase
		return n;
	endfunction

	function automatic logic [15:0] word_limit(input logic [3:0] id);
		logic [15:0] w;
		w = 16'h0000;
		case (id) inside
			4'd0:          w = 16'h08c0;
			4'd1:          w = 16'hd400;
			4'd2:          w = 16'h0010;
			4'd3:          w = 16'h0092;
			[4'd4:4'd10]:  w = 16'h0400;
			default:       w = 16'h0000;
		endcase
		return w;
	endfunction

	// character of a name at a position, 0 past its end
	function automatic logic [7:0] name_char(input logic [3:0] id, input logic [LEN_W-1:0] pos);
		logic [7:0] c;
		c = 8'h00;
		if (id == 4'd0) begin
			if (pos < LEN_W'(7))
				c = UTIL_TXT[8*(6-int'(pos)) +: 8];
		end else if (id <= 4'd3) begin
			if (pos < LEN_W'(8))
				c = FW_TXT[8*(7-int'(pos)) +: 8];
			else if (pos == LEN_W'(8))
				c = 8'h30 + {4'h0, id};
		end else if (id <= 4'd10) begin
			if (pos < LEN_W'(6))
				c = CFG_TXT[8*(5-int'(pos)) +: 8];
			else if (pos == LEN_W'(6))
				c = 8'h30 + {4'h0, id - 4'd4};
		end
		return c;
	endfunction

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
	endfunction

	// hex digit value, 31 when not a digit
	function automatic logic [4:0] digit_val(input logic [7:0] c);
		logic [7:0] l;
		l = c | 8'h20;
		if (c >= 8'h30 && c <= 8'h39)
			return 5'(c - 8'h30);
		else if (l >= 8'h61 && l <= 8'h66)
			return 5'(l - 8'h57);
		else
			return 5'd31;
	endfunction

endpackage

`default_nettype wire

/* sv/fbtp_parse.sv */
// Per-character parse step: next parser state and up to three results.
// Depends on fbtp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fbtp_parse (
	input  fbtp_pkg::parse_state_t                    st,
	input  logic [7:0]                                ch,
	input  logic                                      last,
	output fbtp_pkg::parse_state_t                    st_next,
	output fbtp_pkg::result_t [fbtp_pkg::MAX_RES-1:0] res,
	output logic [1:0]                                n_res
);
	import fbtp_pkg::*;

	localparam logic [7:0] CH_NL   = 8'h0A;
	localparam logic [7:0] CH_NUL  = 8'h00;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_X    = 8'h78;

	function automatic result_t mk(input kind_t k, input logic [3:0] id,
		input logic [15:0] idx, input logic [31:0] val, input err_t e);
		return '{kind: k, image_id: id, word_index: idx, word_value: val,
			error_code: e, final_res: 1'b0};
	endfunction

	function automatic logic [3:0] err_id(input phase_t p, input logic [3:0] cur);
		return (p == PH_COUNT || p == PH_DATA) ? cur : 4'd0;
	endfunction

	logic [LEN_W-1:0]       pos;
	logic [7:0]             lc;
	logic [4:0]             dv;
	logic                   base16;
	logic [35:0]            acc_mul;
	logic [35:0]            acc_sum;
	logic                   num_ok;
	logic                   do_fin;
	logic [IMAGE_KINDS-1:0] cand;
	logic [3:0]             first;

	assign pos     = st.line_length;
	assign lc      = to_lower(ch);
	assign dv      = digit_val(ch);
	assign base16  = (st.phase != PH_COUNT);
	assign acc_mul = base16 ? {st.acc, 4'b0000}
		: ({1'b0, st.acc, 3'b000} + {3'b000, st.acc, 1'b0});
	assign acc_sum = acc_mul + {32'h0, dv[3:0]};

	always_comb begin
		st_next = st;
		res     = '0;
		n_res   = 2'd0;
		num_ok  = 1'b0;
		do_fin  = 1'b0;
		cand    = '0;
		first   = 4'd0;

		// character
		if (st.phase != PH_FAIL && ch != CH_NL) begin
			if (pos == LEN_W'(LINE_LIMIT - 1)) begin
				res[n_res] = mk(KIND_ERROR, err_id(st.phase, st.cur_image), '0, '0,
					ERR_TOO_LONG);
				n_res = n_res + 2'd1;
				st_next.phase = PH_FAIL;
			end else begin
				st_next.line_length = pos + LEN_W'(1);
				if (!st.line_stopped) begin
					if (ch == CH_NUL) begin
						st_next.line_stopped = 1'b1;
						if (st.phase == PH_NAME)
							for (int i = 0; i < IMAGE_KINDS; i++)
								if (LEN_W'(name_len(4'(i))) != pos)
									st_next.name_candidates[i] = 1'b0;
					end else if (st.phase == PH_NAME) begin
						for (int i = 0; i < IMAGE_KINDS; i++)
							if (name_char(4'(i), pos) != lc)
								st_next.name_candidates[i] = 1'b0;
					end else if (st.form != F_BAD) begin
						if (st.form == F_START && ch == CH_PLUS)
							st_next.form = F_PLUS;
						else if (st.form == F_ZERO && base16 && (ch | 8'h20) == CH_X)
							st_next.form = F_PREFIX;
						else if (base16 ? (dv >= 5'd16) : (dv >= 5'd10))
							st_next.form = F_BAD;
						else begin
							st_next.acc = acc_sum[31:0];
							if (acc_sum[35:32] != 4'h0)
								st_next.ovf = 1'b1;
							if (base16 && dv == 5'd0 && (st.form == F_START || st.form == F_PLUS))
								st_next.form = F_ZERO;
							else
								st_next.form = F_DIGITS;
						end
					end
				end
			end
		end

		// line end
		if (st_next.phase != PH_FAIL && st_next.line_length != '0 && (ch == CH_NL || last)) begin
			num_ok = (st_next.form == F_ZERO || st_next.form == F_DIGITS) && !st_next.ovf;
			unique case (st_next.phase)
				PH_NAME: begin
					cand = st_next.name_candidates;
					if (!st_next.line_stopped)
						for (int i = 0; i < IMAGE_KINDS; i++)
							if (LEN_W'(name_len(4'(i))) != st_next.line_length)
								cand[i] = 1'b0;
					for (int i = IMAGE_KINDS - 1; i >= 0; i--)
						if (cand[i])
							first = 4'(i);
					if (cand == '0) begin
						res[n_res] = mk(KIND_ERROR, 4'd0, '0, '0, ERR_UNKNOWN);
						n_res = n_res + 2'd1;
						st_next.phase = PH_FAIL;
					end else begin
						st_next.cur_image = first;
						st_next.phase = PH_COUNT;
					end
				end
				PH_COUNT: begin
					if (!num_ok) begin
						res[n_res] = mk(KIND_ERROR, st_next.cur_image, '0, '0, ERR_BAD_SIZE);
						n_res = n_res + 2'd1;
						st_next.phase = PH_FAIL;
					end else if (st_next.cur_image >= 4'(IMAGE_KINDS)
						|| st_next.acc > {16'h0, word_limit(st_next.cur_image)}) begin
						res[n_res] = mk(KIND_ERROR, st_next.cur_image, '0, '0, ERR_TOO_BIG);
						n_res = n_res + 2'd1;
						st_next.phase = PH_FAIL;
					end else begin
						st_next.words_expected = st_next.acc[15:0];
						st_next.words_done = 16'h0;
						if (st_next.acc[15:0] == 16'h0)
							do_fin = 1'b1;
						else
							st_next.phase = PH_DATA;
					end
				end
				PH_DATA: begin
					if (!num_ok) begin
						res[n_res] = mk(KIND_ERROR, st_next.cur_image, '0, '0, ERR_BAD_DATA);
						n_res = n_res + 2'd1;
						st_next.phase = PH_FAIL;
					end else begin
						res[n_res] = mk(KIND_WORD, st_next.cur_image, st_next.words_done,
							st_next.acc, ERR_TOO_LONG);
						n_res = n_res + 2'd1;
						st_next.words_done = st_next.words_done + 16'h1;
						if (st_next.words_done >= st_next.words_expected)
							do_fin = 1'b1;
					end
				end
				default: ;
			endcase
			if (do_fin) begin
				if (st_next.images_seen[st_next.cur_image]) begin
					res[n_res] = mk(KIND_ERROR, st_next.cur_image, '0, '0, ERR_DUPLICATE);
					n_res = n_res + 2'd1;
					st_next.phase = PH_FAIL;
				end else begin
					st_next.images_seen[st_next.cur_image] = 1'b1;
					res[n_res] = mk(KIND_IMAGE, st_next.cur_image, st_next.words_expected,
						'0, ERR_TOO_LONG);
					n_res = n_res + 2'd1;
					st_next.phase = PH_NAME;
				end
			end
			st_next.line_length     = '0;
			st_next.name_candidates = '1;
			st_next.acc             = '0;
			st_next.ovf             = 1'b0;
			st_next.form            = F_START;
			st_next.line_stopped    = 1'b0;
		end

		// end of bundle
		if (last) begin
			unique case (st_next.phase)
				PH_NAME: begin
					if (st_next.images_seen[0])
						res[n_res] = mk(KIND_ACCEPT, 4'd0, '0, '0, ERR_TOO_LONG);
					else
						res[n_res] = mk(KIND_ERROR, 4'd0, '0, '0, ERR_NO_UTILITY);
					n_res = n_res + 2'd1;
				end
				PH_COUNT: begin
					res[n_res] = mk(KIND_ERROR, st_next.cur_image, '0, '0, ERR_NO_SIZE);
					n_res = n_res + 2'd1;
				end
				PH_DATA: begin
					res[n_res] = mk(KIND_ERROR, st_next.cur_image, '0, '0, ERR_NO_DATA);
					n_res = n_res + 2'd1;
				end
				default: ;
			endcase
			st_next = STATE_RESET;
		end

		if (n_res != 2'd0)
			res[n_res - 2'd1].final_res = 1'b1;
	end

endmodule

`default_nettype wire

/* sv/fbtp_outq.sv */
// Result queue of up to three results per character, drained one per cycle while head_ready is high.
// Depends on fbtp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fbtp_outq (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  fbtp_pkg::q_load_t                         ld,
	input  fbtp_pkg::result_t [fbtp_pkg::MAX_RES-1:0] res_in,
	output logic                                      can_load,
	output fbtp_pkg::result_t                         head,
	output logic                                      head_valid,
	input  logic                                      head_ready
);
	import fbtp_pkg::*;

	result_t [MAX_RES-1:0] res_q;
	logic [1:0]            cnt_q;
	logic                  pop;

	assign head_valid = (cnt_q != 2'd0);
	assign pop        = head_valid && head_ready;
	assign can_load   = (cnt_q == 2'd0) || (cnt_q == 2'd1 && head_ready);
	assign head       = res_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (ld.load) begin
			cnt_q <= ld.count;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (ld.load) begin
			res_q <= res_in;
		end else if (pop) begin
			res_q[0] <= res_q[1];
			res_q[1] <= res_q[2];
		end
	end

endmodule

`default_nettype wire

/* sv/firmware_bundle_text_parser_core.sv */
// Firmware bundle text parser, top level.
// Depends on fbtp_pkg, fbtp_parse and fbtp_outq.
//
// Input channel (in_valid/in_ready): one bundle character per request in
// byte_in; last marks the final character and also ends the open line.
// Output channel (out_valid/out_ready): result requests carrying kind,
// image_id, word_index, word_value, error_code and final_res; final_res
// marks the last result a character produced. A character yields 0 to 3
// results.
// An accepted character is registered in the input register and parsed
// from there; the parser state and its results are registered when the
// result queue can take them, and results are offered from the queue head.
// Throughput: one character per cycle while each character yields at most
// one result and out_ready is high; more results stall it as the queue drains.
// Reset clears the parser to expect an image name with no images seen, and
// empties the input register and the result queue.
// When the receiver stalls, results wait in the queue, the next character
// waits in the input register, and in_ready drops once both are held.
`timescale 1ns / 1ps
`default_nettype none

module firmware_bundle_text_parser_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  byte_in,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [3:0]  image_id,
	output logic [15:0] word_index,
	output logic [31:0] word_value,
	output logic [3:0]  error_code,
	output logic        final_res
);
	import fbtp_pkg::*;

	logic                  valid_s1;
	logic [7:0]            byte_s1;
	logic                  last_s1;
	logic                  consume;
	logic                  can_load;
	parse_state_t          state_q;
	parse_state_t          state_next;
	result_t [MAX_RES-1:0] res;
	logic [1:0]            n_res;
	q_load_t               ld;
	result_t               head;

	assign consume  = valid_s1 && can_load;
	assign in_ready = !valid_s1 || consume;
	assign ld.load  = consume && (n_res != 2'd0);
	assign ld.count = n_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= byte_in;
			last_s1 <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (consume) begin
			state_q <= state_next;
		end
	end

	fbtp_parse u_parse (
		.st      (state_q),
		.ch      (byte_s1),
		.last    (last_s1),
		.st_next (state_next),
		.res     (res),
		.n_res   (n_res)
	);

	fbtp_outq u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.ld         (ld),
		.res_in     (res),
		.can_load   (can_load),
		.head       (head),
		.head_valid (out_valid),
		.head_ready (out_ready)
	);

	assign kind       = head.kind;
	assign image_id   = head.image_id;
	assign word_index = head.word_index;
	assign word_value = head.word_value;
	assign error_code = head.error_code;
	assign final_res  = head.final_res;

endmodule

`default_nettype wire

/* sv/fbtp_checker.sv */
// Port-level checks of the bundle text parser, bound to its top level.
// Depends on fbtp_pkg and firmware_bundle_text_parser_core_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "firmware_bundle_text_parser_core_defines.svh"

module fbtp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [7:0]  byte_in,
	input logic        last,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  kind,
	input logic [3:0]  image_id,
	input logic [15:0] word_index,
	input logic [31:0] word_value,
	input logic [3:0]  error_code,
	input logic        final_res
);
	import fbtp_pkg::*;

	logic unused_in;
	assign unused_in = in_valid ^ in_ready ^ (^byte_in) ^ last;

	`FBTP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(word_value) && $stable(kind) && $stable(final_res))
	`FBTP_ASSERT_NOW(a_value_only_word, out_valid && kind != KIND_WORD, word_value == 32'h0)
	`FBTP_ASSERT_NOW(a_code_only_error, out_valid && kind != KIND_ERROR, error_code == ERR_TOO_LONG)
	`FBTP_ASSERT_NOW(a_accept_last, out_valid && kind == KIND_ACCEPT, final_res && image_id == 4'd0 && word_index == 16'h0)

endmodule

bind firmware_bundle_text_parser_core fbtp_checker u_fbtp_checker (.*);

`default_nettype wire

/* bench/tb.sv */
// Testbench for firmware_bundle_text_parser_core: directed bundle lines, then random bundles,
// every result checked against a directed row or a behavioral parser fed accepted characters.
// Depends on fbtp_pkg and the RTL of the parser.
`timescale 1ns / 1ps

module tb;
	import fbtp_pkg::*;

	localparam int   STALL_LIMIT = 2000;
	localparam int   SHOW_MAX    = 40;
	localparam err_t NO_ERR      = '0;
	localparam int   DIR_ROWS    = 22;

	typedef struct packed {
		logic        fin;
		logic        chk;
		kind_t       kind;
		logic [3:0]  id;
		logic [15:0] idx;
		logic [31:0] val;
		err_t        err;
	} dir_row_t;

	localparam dir_row_t ROW_MID = '{1'b0, 1'b0, KIND_WORD, 4'd0, 16'd0, 32'd0, NO_ERR};
	localparam dir_row_t ROW_END = '{1'b1, 1'b0, KIND_WORD, 4'd0, 16'd0, 32'd0, NO_ERR};

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  byte_in;
	logic        last;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  kind;
	logic [3:0]  image_id;
	logic [15:0] word_index;
	logic [31:0] word_value;
	logic [3:0]  error_code;
	logic        final_res;

	// typed expectation, held with the request it belongs to
	logic        want_on;
	result_t     want_res;

	int send_idle;
	int recv_idle;
	int stall_cycles;
	int mismatches;
	int bytes_taken;
	int results_predicted;

	string img_text [IMAGE_KINDS] = '{"utility", "firmware1", "firmware2", "firmware3",
		"config0", "config1", "config2", "config3", "config4", "config5", "config6"};
	logic [15:0] img_cap [IMAGE_KINDS] = '{16'h08c0, 16'hd400, 16'h0010, 16'h0092,
		16'h0400, 16'h0400, 16'h0400, 16'h0400, 16'h0400, 16'h0400, 16'h0400};

	// '^' stands for a NUL byte
	string dir_text [DIR_ROWS] = '{
		"\nUTILITY\n+3\n",
		"0x0\n",
		"FFFFFFFF\n",
		"+0Xa\n\nconfig6\n",
		"00\n",
		"fIrMwArE2\n1\nabc^zz\nconfig1\n",
		"0",
		"firmware1",
		"config0\n1025\n",
		"\n",
		"firmware\n",
		"x",
		"utility\n4294967296\n",
		"\n",
		"config2\n1\n0x1ffffffff\n",
		"\n",
		"utility\n0\nUTILITY\n0\n",
		"\n",
		"config3\n0\n\n",
		"config5\n2\n7",
		"abcdefghijklmnopqrstuvwxyz012345",
		"\377"
	};

	dir_row_t dir_ctl [DIR_ROWS] = '{
		ROW_MID,
		'{1'b0, 1'b1, KIND_WORD, 4'd0, 16'd0, 32'h0000_0000, NO_ERR},
		'{1'b0, 1'b1, KIND_WORD, 4'd0, 16'd1, 32'hFFFF_FFFF, NO_ERR},
		ROW_MID,
		'{1'b0, 1'b1, KIND_IMAGE, 4'd10, 16'd0, 32'd0, NO_ERR},
		ROW_MID,
		ROW_END,
		'{1'b1, 1'b1, KIND_ERROR, 4'd1, 16'd0, 32'd0, ERR_NO_SIZE},
		'{1'b0, 1'b1, KIND_ERROR, 4'd4, 16'd0, 32'd0, ERR_TOO_BIG},
		ROW_END,
		'{1'b0, 1'b1, KIND_ERROR, 4'd0, 16'd0, 32'd0, ERR_UNKNOWN},
		ROW_END,
		'{1'b0, 1'b1, KIND_ERROR, 4'd0, 16'd0, 32'd0, ERR_BAD_SIZE},
		ROW_END,
		'{1'b0, 1'b1, KIND_ERROR, 4'd6, 16'd0, 32'd0, ERR_BAD_DATA},
		ROW_END,
		'{1'b0, 1'b1, KIND_ERROR, 4'd0, 16'd0, 32'd0, ERR_DUPLICATE},
		ROW_END,
		'{1'b1, 1'b1, KIND_ERROR, 4'd0, 16'd0, 32'd0, ERR_NO_UTILITY},
		ROW_END,
		'{1'b0, 1'b1, KIND_ERROR, 4'd0, 16'd0, 32'd0, ERR_TOO_LONG},
		ROW_END
	};

	// parser state as predicted
	phase_t      stage;
	int          line_len;
	logic [10:0] name_mask;
	logic [31:0] num_acc;
	logic        num_ovf;
	form_t       num_form;
	logic [3:0]  img;
	logic [15:0] want_words;
	logic [15:0] got_words;
	logic [10:0] seen_mask;
	logic        line_cut;

	result_t     byte_results[$];
	result_t     results_due[$];
	result_t     due_now;
	logic [7:0]  bundle_q[$];

	firmware_bundle_text_parser_core u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.byte_in    (byte_in),
		.last       (last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.kind       (kind),
		.image_id   (image_id),
		.word_index (word_index),
		.word_value (word_value),
		.error_code (error_code),
		.final_res  (final_res)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic void note(kind_t k, logic [3:0] id, logic [15:0] idx, logic [31:0] val,
			err_t e);
		if (byte_results.size() < MAX_RES)
			byte_results.push_back(result_t'{k, id, idx, val, e, 1'b0});
	endfunction

	function automatic void abort_bundle(err_t e);
		note(KIND_ERROR, (stage == PH_COUNT || stage == PH_DATA) ? img : 4'd0, '0, '0, e);
		stage = PH_FAIL;
	endfunction

	function automatic void fresh_line();
		line_len  = 0;
		name_mask = '1;
		num_acc   = '0;
		num_ovf   = 1'b0;
		num_form  = F_START;
		line_cut  = 1'b0;
	endfunction

	function automatic void clear_all();
		stage      = PH_NAME;
		img        = '0;
		want_words = '0;
		got_words  = '0;
		seen_mask  = '0;
		fresh_line();
	endfunction

	function automatic void drop_len(int n);
		for (int i = 0; i < IMAGE_KINDS; i++)
			if (img_text[i].len() != n)
				name_mask[i] = 1'b0;
	endfunction

	function automatic void match_name(logic [7:0] c, int pos);
		logic [7:0] l;
		l = (c >= "A" && c <= "Z") ? c + 8'h20 : c;
		for (int i = 0; i < IMAGE_KINDS; i++)
			if (pos >= img_text[i].len() || img_text[i][pos] != l)
				name_mask[i] = 1'b0;
	endfunction

	function automatic void take_digit(logic [7:0] c);
		int unsigned base;
		int unsigned d;
		logic [7:0]  l;
		logic [63:0] wide;
		base = (stage == PH_COUNT) ? 10 : 16;
		l = c | 8'h20;
		if (num_form == F_BAD)
			return;
		if (num_form == F_START && c == "+") begin
			num_form = F_PLUS;
			return;
		end
		if (num_form == F_ZERO && base == 16 && l == "x") begin
			num_form = F_PREFIX;
			return;
		end
		if (c >= "0" && c <= "9")
			d = c - "0";
		else if (l >= "a" && l <= "f")
			d = l - "a" + 10;
		else
			d = 99;
		if (d >= base) begin
			num_form = F_BAD;
			return;
		end
		wide = {32'd0, num_acc} * base + d;
		if (wide > 64'hFFFF_FFFF)
			num_ovf = 1'b1;
		num_acc = wide[31:0];
		if (base == 16 && d == 0 && (num_form == F_START || num_form == F_PLUS))
			num_form = F_ZERO;
		else
			num_form = F_DIGITS;
	endfunction

	function automatic bit num_good();
		return (num_form == F_ZERO || num_form == F_DIGITS) && !num_ovf;
	endfunction

	function automatic void close_image();
		if (seen_mask[img]) begin
			abort_bundle(ERR_DUPLICATE);
			return;
		end
		seen_mask[img] = 1'b1;
		note(KIND_IMAGE, img, want_words, '0, NO_ERR);
		stage = PH_NAME;
	endfunction

	function automatic void end_of_line();
		int first;
		first = -1;
		case (stage)
			PH_NAME: begin
				if (!line_cut)
					drop_len(line_len);
				for (int i = IMAGE_KINDS - 1; i >= 0; i--)
					if (name_mask[i])
						first = i;
				if (first < 0) begin
					abort_bundle(ERR_UNKNOWN);
				end else begin
					img   = 4'(first);
					stage = PH_COUNT;
				end
			end
			PH_COUNT: begin
				if (!num_good()) begin
					abort_bundle(ERR_BAD_SIZE);
				end else if (num_acc > {16'd0, img_cap[img]}) begin
					abort_bundle(ERR_TOO_BIG);
				end else begin
					want_words = num_acc[15:0];
					got_words  = '0;
					if (want_words == 0)
						close_image();
					else
						stage = PH_DATA;
				end
			end
			PH_DATA: begin
				if (!num_good()) begin
					abort_bundle(ERR_BAD_DATA);
				end else begin
					note(KIND_WORD, img, got_words, num_acc, NO_ERR);
					got_words = got_words + 16'd1;
					if (got_words >= want_words)
						close_image();
				end
			end
			default: ;
		endcase
		fresh_line();
	endfunction

	function automatic void take_byte(logic [7:0] c);
		int pos;
		pos = line_len;
		if (pos + 1 >= LINE_LIMIT) begin
			abort_bundle(ERR_TOO_LONG);
			return;
		end
		line_len = pos + 1;
		if (line_cut)
			return;
		if (c == 8'h00) begin
			line_cut = 1'b1;
			if (stage == PH_NAME)
				drop_len(pos);
			return;
		end
		if (stage == PH_NAME)
			match_name(c, pos);
		else
			take_digit(c);
	endfunction

	function automatic void parse_byte(logic [7:0] c, logic fin);
		result_t tail;
		byte_results.delete();
		if (stage != PH_FAIL) begin
			if (c == 8'h0A) begin
				if (line_len > 0)
					end_of_line();
			end else begin
				take_byte(c);
			end
		end
		if (fin) begin
			if (stage != PH_FAIL && line_len > 0)
				end_of_line();
			case (stage)
				PH_NAME: begin
					if (seen_mask[0])
						note(KIND_ACCEPT, '0, '0, '0, NO_ERR);
					else
						abort_bundle(ERR_NO_UTILITY);
				end
				PH_COUNT: abort_bundle(ERR_NO_SIZE);
				PH_DATA:  abort_bundle(ERR_NO_DATA);
				default: ;
			endcase
			clear_all();
		end
		if (byte_results.size() > 0) begin
			tail = byte_results.pop_back();
			tail.final_res = 1'b1;
			byte_results.push_back(tail);
		end
	endfunction

	function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= SHOW_MAX)
				$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
		end
	endfunction

	// predict on every accepted character, check every accepted result
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				bytes_taken++;
				parse_byte(byte_in, last);
				if (want_on) begin
					results_due.push_back(want_res);
					results_predicted++;
				end else begin
					foreach (byte_results[i])
						results_due.push_back(byte_results[i]);
					results_predicted += byte_results.size();
				end
			end
			if (out_valid && out_ready) begin
				if (results_due.size() == 0) begin
					mismatches++;
					if (mismatches <= SHOW_MAX)
						$display("%0t: result with none pending, expected nothing, actual kind %0d",
							$time, kind);
				end else begin
					due_now = results_due.pop_front();
					check_field("kind", due_now.kind, kind);
					check_field("image_id", due_now.image_id, image_id);
					check_field("word_index", due_now.word_index, word_index);
					check_field("word_value", due_now.word_value, word_value);
					check_field("error_code", due_now.error_code, error_code);
					check_field("final_res", due_now.final_res, final_res);
				end
			end
		end
	end

	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= recv_idle);

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	task automatic send_byte(logic [7:0] b, logic fin, logic chk, result_t want);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		byte_in  <= b;
		last     <= fin;
		want_on  <= chk;
		want_res <= want;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic put_text(string s, bit mix);
		logic [7:0] c;
		for (int i = 0; i < s.len(); i++) begin
			c = s[i];
			if (mix && c >= "a" && c <= "z" && $urandom_range(1))
				c = c - 8'h20;
			bundle_q.push_back(c);
		end
	endtask

	task automatic put_word();
		string       s;
		logic [31:0] v;
		int          r;
		r = $urandom_range(24);
		v = $urandom();
		if (r == 5)
			v = '0;
		if (r == 6)
			v = '1;
		s = $sformatf("%0h", v);
		if ($urandom_range(3) == 0)
			s = {"0", s};
		if ($urandom_range(2) == 0)
			s = {"0x", s};
		if ($urandom_range(4) == 0)
			s = {"+", s};
		case (r)
			0: s = {s, "g"};
			1: s = "0x";
			2: s = $sformatf("1%08h", v);
			4: s = {"00000000000000000000000000000000", s};
			default: ;
		endcase
		put_text(s, 1);
		if (r == 3)
			bundle_q.insert(bundle_q.size() - $urandom_range(s.len()), 8'h00);
		put_text("\n", 0);
	endtask

	// mostly well-formed bundles with random content, some noise and broken ones
	task automatic gen_bundle();
		int    n_img, util_at, id, cnt, r, cut;
		string s;
		bundle_q.delete();
		if ($urandom_range(9) == 0) begin
			repeat ($urandom_range(1, 30))
				bundle_q.push_back(($urandom_range(7) == 0) ? 8'h0A : 8'($urandom_range(255)));
		end else begin
			n_img   = $urandom_range(1, 4);
			util_at = ($urandom_range(9) < 7) ? $urandom_range(n_img - 1) : -1;
			for (int k = 0; k < n_img; k++) begin
				id = (k == util_at) ? 0 : $urandom_range(IMAGE_KINDS - 1);
				s  = img_text[id];
				r  = $urandom_range(19);
				if (r == 0)
					s[$urandom_range(s.len() - 1)] = 8'($urandom_range(8'h61, 8'h7A));
				else if (r == 1)
					s = {s, "7"};
				if ($urandom_range(9) == 0)
					put_text("\n", 0);
				put_text({s, "\n"}, 1);
				r   = $urandom_range(19);
				cnt = $urandom_range(3);
				if (r == 3 && id == 2)
					cnt = 16;
				s = $sformatf("%0d", cnt);
				if ($urandom_range(4) == 0)
					s = {"0", s};
				if ($urandom_range(4) == 0)
					s = {"+", s};
				if (r == 0)
					s = $sformatf("%0d", img_cap[id] + 1);
				else if (r == 1)
					s = "1z";
				else if (r == 2)
					s = "99999999999";
				if (r <= 2)
					cnt = 1;
				put_text({s, "\n"}, 0);
				for (int w = 0; w < cnt; w++)
					put_word();
			end
			r = $urandom_range(11);
			if (r == 0) begin
				cut = $urandom_range(1, bundle_q.size());
				while (bundle_q.size() > cut)
					void'(bundle_q.pop_back());
			end else if (r < 6 && bundle_q.size() > 1) begin
				void'(bundle_q.pop_back());
			end
		end
	endtask

	initial begin
		string      s;
		logic [7:0] c;
		logic       at_end;
		result_t    want;
		int         b0, r0;
		in_valid          = 1'b0;
		byte_in           = '0;
		last              = 1'b0;
		out_ready         = 1'b0;
		arst_n            = 1'b0;
		want_on           = 1'b0;
		want_res          = '0;
		stall_cycles      = 0;
		mismatches        = 0;
		bytes_taken       = 0;
		results_predicted = 0;
		send_idle         = 32;
		recv_idle         = 72;
		clear_all();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < DIR_ROWS; r++) begin
			s    = dir_text[r];
			want = result_t'{dir_ctl[r].kind, dir_ctl[r].id, dir_ctl[r].idx, dir_ctl[r].val,
				dir_ctl[r].err, 1'b1};
			for (int i = 0; i < s.len(); i++) begin
				c      = (s[i] == "^") ? 8'h00 : s[i];
				at_end = (i == s.len() - 1);
				send_byte(c, dir_ctl[r].fin && at_end, dir_ctl[r].chk && at_end, want);
			end
		end

		for (int round = 0; round < 3; round++) begin
			send_idle = (round == 0) ? 32 : (round == 1) ? 72 : 0;
			recv_idle = (round == 0) ? 72 : (round == 1) ? 32 : 0;
			b0 = bytes_taken;
			r0 = results_predicted;
			while (bytes_taken - b0 < 70 || results_predicted - r0 < 20) begin
				gen_bundle();
				foreach (bundle_q[i])
					send_byte(bundle_q[i], i == bundle_q.size() - 1, 1'b0, '0);
			end
		end
		in_valid <= 1'b0;

		while (results_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
